// ===== sv/buddy_block_allocator_top_defines.svh =====
// Assertion macros shared by the checker file.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BBA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bba assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bba assertion failed");

`endif

// ===== sv/bba_pkg.sv =====
package bba_pkg;

   localparam int LEVELS = 11;
   localparam int LINK_W = 11;
   localparam int LV_W   = 4;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam logic [LINK_W-1:0] NIL = 11'h7FF;

   typedef enum logic [1:0] {
      MODE_INIT  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INIT_NEXT,
      S_ALLOC_POP,
      S_SPLIT,
      S_FREE_LEVEL,
      S_WALK,
      S_WALK_WAIT,
      S_UNLINK,
      S_APPEND,
      S_APPEND_TAIL,
      S_RETURN
   } state_type;

   // smallest lv with 2^lv >= n
   function automatic logic [LV_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
      logic [LV_W-1:0] r;
      r = 4'd11;
      for (int lv = 11; lv >= 0; lv--) begin
         if ((12'(1) << lv) >= {1'b0, n}) r = 4'(lv);
      end
      return r;
   endfunction

   // largest lv with 2^lv <= n, 0 for n below 2
   function automatic logic [LV_W-1:0] floor_log2(input logic [CNT_W-1:0] n);
      logic [LV_W-1:0] r;
      r = '0;
      for (int lv = 0; lv < 10; lv++) begin
         if ((12'(2) << lv) <= {1'b0, n}) r = 4'(lv + 1);
      end
      return r;
   endfunction

endpackage

// ===== sv/bba_link_ram.sv =====
module bba_link_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/buddy_block_allocator_top.sv =====
// Mode 3, failed allocs and rejected frees answer from decode; an alloc pops a list head and then
// splits down level by level; a free merges upward, walking each level list for the buddy, then appends.
// Init frees the pool block by block, each with its merge walks; one request is handled at a time.
// The link memory has separate read and write ports; each level list is walked one entry per read.
// Synchronous active-high reset empties all lists and the pool; link memory is not cleared.
// The receiver cannot stall: each result beat is shown for one cycle only.
module buddy_block_allocator_top #(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_mode,
   input  logic [bba_pkg::CNT_W-1:0] req_block_count,
   input  logic [bba_pkg::IDX_W-1:0] req_block_index,
   output logic                     rsp_valid,
   output logic                     rsp_ok,
   output logic [bba_pkg::IDX_W-1:0] rsp_granted_index
);
   import bba_pkg::*;

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int SW = $clog2(NUM_BLOCKS + 2);

   state_type state_ff, state_in;

   // captured request
   logic [1:0]        mode_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [IDX_W-1:0]  rindex_ff;

   // allocator state
   logic [LINK_W-1:0] head_ff [LEVELS];
   logic [LINK_W-1:0] tail_ff [LEVELS];
   logic [LV_W-1:0]   top_ff, top_in;
   logic [CNT_W-1:0]  pool_ff, pool_in;

   // walk / sequencer registers
   logic [LINK_W-1:0] idx_ff, idx_in;
   logic [LV_W-1:0]   lv_ff, lv_in;
   logic [LV_W-1:0]   want_ff, want_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [SW-1:0]     steps_ff, steps_in;
   logic [CNT_W-1:0]  init_ff, init_in;
   logic [LINK_W-1:0] blk_ff, blk_in;
   logic [LINK_W-1:0] app_ff, app_in;
   logic [LINK_W-1:0] app_tail_ff, app_tail_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [IDX_W-1:0]  rsp_grant_ff, rsp_grant_in;

   // list end updates at level lv_ff, and a clear of all lists
   logic              lists_clr;
   logic              head_we, tail_we;
   logic [LINK_W-1:0] head_wd, tail_wd;

   // link memory
   logic              wr_en, rd_en;
   logic [LINK_W-1:0] wr_addr_l, wr_data, rd_addr_l, rd_data;

   // shared decode terms
   logic [LINK_W-1:0] lv_bit, mate, head_lv, tail_lv;
   logic [CNT_W-1:0]  pool_sat;
   logic [LV_W-1:0]   want_c, free_lv_c;
   logic              hit;
   logic [LV_W-1:0]   hit_lv;
   logic              free_go, walk_end, walk_match, init_more, app_in_pool;
   logic              split_more;

   bba_link_ram #(.DEPTH(NUM_BLOCKS), .AW(AW), .DW(LINK_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(wr_addr_l)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (AW'(rd_addr_l)),
      .rd_data (rd_data)
   );

   assign lv_bit   = LINK_W'(1) << lv_ff;
   assign mate     = idx_ff ^ lv_bit;
   assign head_lv  = head_ff[lv_ff];
   assign tail_lv  = tail_ff[lv_ff];
   assign pool_sat = (32'(cnt_ff) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : cnt_ff;
   assign want_c   = ceil_log2(cnt_ff);
   assign free_lv_c = want_c;
   assign free_go  = ({1'b0, rindex_ff} < pool_ff) && (free_lv_c <= top_ff);
   assign walk_end = (cur_ff == NIL) || (32'(steps_ff) > 32'(NUM_BLOCKS));
   assign walk_match = (cur_ff == mate);
   assign init_more  = (init_ff < pool_ff);
   assign app_in_pool = (app_ff < pool_ff);
   assign split_more  = (lv_ff > want_ff);

   // first non-empty list at or above the wanted level, up to the top level
   always_comb begin
      hit    = 1'b0;
      hit_lv = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if ((4'(i) >= want_c) && (4'(i) <= top_ff) && (head_ff[i] != NIL)) begin
            hit    = 1'b1;
            hit_lv = 4'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            priority case (mode_ff)
               MODE_INIT:  state_in = S_INIT_NEXT;
               MODE_ALLOC: state_in = hit ? S_ALLOC_POP : S_IDLE;
               MODE_FREE:  state_in = free_go ? S_FREE_LEVEL : S_IDLE;
               default:    state_in = S_IDLE;
            endcase
         end
         S_INIT_NEXT:   state_in = init_more ? S_FREE_LEVEL : S_IDLE;
         S_ALLOC_POP:   state_in = S_SPLIT;
         S_SPLIT:       state_in = split_more ? S_APPEND : S_IDLE;
         S_FREE_LEVEL:  state_in = (lv_ff < top_ff) ? S_WALK : S_APPEND;
         S_WALK: begin
            priority if (walk_end)   state_in = S_APPEND;
            else if (walk_match)     state_in = S_UNLINK;
            else                     state_in = S_WALK_WAIT;
         end
         S_WALK_WAIT:   state_in = S_WALK;
         S_UNLINK:      state_in = S_FREE_LEVEL;
         S_APPEND: begin
            if (app_in_pool && (head_lv != NIL)) state_in = S_APPEND_TAIL;
            else                                 state_in = S_RETURN;
         end
         S_APPEND_TAIL: state_in = S_RETURN;
         S_RETURN: begin
            priority case (mode_ff)
               MODE_INIT:  state_in = S_INIT_NEXT;
               MODE_ALLOC: state_in = S_SPLIT;
               default:    state_in = S_IDLE;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath, memory and result controls
   always_comb begin
      top_in      = top_ff;
      pool_in     = pool_ff;
      idx_in      = idx_ff;
      lv_in       = lv_ff;
      want_in     = want_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      steps_in    = steps_ff;
      init_in     = init_ff;
      blk_in      = blk_ff;
      app_in      = app_ff;
      app_tail_in = app_tail_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_grant_in = rsp_grant_ff;
      lists_clr = 1'b0;
      head_we   = 1'b0;
      tail_we   = 1'b0;
      head_wd   = NIL;
      tail_wd   = NIL;
      wr_en     = 1'b0;
      wr_addr_l = app_ff;
      wr_data   = NIL;
      rd_en     = 1'b0;
      rd_addr_l = cur_ff;
      unique case (state_ff)
         S_IDLE: ;
         S_DECODE: begin
            priority case (mode_ff)
               MODE_INIT: begin
                  // empty all lists, size the pool, then free block by block
                  lists_clr = 1'b1;
                  pool_in   = pool_sat;
                  top_in    = (pool_sat == '0) ? '0 : floor_log2(pool_sat);
                  init_in   = '0;
               end
               MODE_ALLOC: begin
                  want_in = want_c;
                  if (hit) begin
                     blk_in    = head_ff[hit_lv];
                     lv_in     = hit_lv;
                     rd_en     = 1'b1;
                     rd_addr_l = head_ff[hit_lv];
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_grant_in = '0;
                  end
               end
               MODE_FREE: begin
                  if (free_go) begin
                     idx_in = {1'b0, rindex_ff};
                     lv_in  = free_lv_c;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b1;
                     rsp_grant_in = '0;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_grant_in = '0;
               end
            endcase
         end
         S_INIT_NEXT: begin
            if (init_more) begin
               idx_in = init_ff;
               lv_in  = '0;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_grant_in = '0;
            end
         end
         S_ALLOC_POP: begin
            // pop the head: its successor becomes the new head
            head_we = 1'b1;
            head_wd = rd_data;
            if (rd_data == NIL) tail_we = 1'b1;
         end
         S_SPLIT: begin
            if (split_more) begin
               lv_in  = lv_ff - 4'd1;
               app_in = blk_ff ^ (LINK_W'(1) << (lv_ff - 4'd1));
            end else begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_grant_in = blk_ff[IDX_W-1:0];
            end
         end
         S_FREE_LEVEL: begin
            cur_in   = head_lv;
            prev_in  = NIL;
            steps_in = '0;
            app_in   = idx_ff;
         end
         S_WALK: begin
            if (!walk_end) begin
               rd_en     = 1'b1;
               rd_addr_l = cur_ff;
               if (!walk_match) begin
                  prev_in  = cur_ff;
                  steps_in = steps_ff + 1'b1;
               end
            end
         end
         S_WALK_WAIT: cur_in = rd_data;
         S_UNLINK: begin
            // drop the buddy from the list, rd_data holds its successor
            if (prev_ff == NIL) begin
               head_we = 1'b1;
               head_wd = rd_data;
               if (rd_data == NIL) tail_we = 1'b1;
            end else begin
               wr_en     = 1'b1;
               wr_addr_l = prev_ff;
               wr_data   = rd_data;
               if (cur_ff == tail_lv) begin
                  tail_we = 1'b1;
                  tail_wd = prev_ff;
               end
            end
            idx_in = (mate < idx_ff) ? mate : idx_ff;
            lv_in  = lv_ff + 4'd1;
         end
         S_APPEND: begin
            if (app_in_pool) begin
               wr_en     = 1'b1;
               wr_addr_l = app_ff;
               wr_data   = NIL;
               tail_we   = 1'b1;
               tail_wd   = app_ff;
               if (head_lv == NIL) begin
                  head_we = 1'b1;
                  head_wd = app_ff;
               end else begin
                  app_tail_in = tail_lv;
               end
            end
         end
         S_APPEND_TAIL: begin
            wr_en     = 1'b1;
            wr_addr_l = app_tail_ff;
            wr_data   = app_ff;
         end
         S_RETURN: begin
            priority case (mode_ff)
               MODE_INIT:  init_in = init_ff + 1'b1;
               MODE_ALLOC: ;
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_grant_in = '0;
               end
            endcase
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         top_ff       <= '0;
         pool_ff      <= '0;
         for (int i = 0; i < LEVELS; i++) head_ff[i] <= NIL;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
         pool_ff      <= pool_in;
         if (lists_clr) begin
            for (int i = 0; i < LEVELS; i++) head_ff[i] <= NIL;
         end else if (head_we) begin
            head_ff[lv_ff] <= head_wd;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         mode_ff   <= req_mode;
         cnt_ff    <= req_block_count;
         rindex_ff <= req_block_index;
      end
      if (lists_clr) begin
         for (int i = 0; i < LEVELS; i++) tail_ff[i] <= NIL;
      end else if (tail_we) begin
         tail_ff[lv_ff] <= tail_wd;
      end
      idx_ff       <= idx_in;
      lv_ff        <= lv_in;
      want_ff      <= want_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      steps_ff     <= steps_in;
      init_ff      <= init_in;
      blk_ff       <= blk_in;
      app_ff       <= app_in;
      app_tail_ff  <= app_tail_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_grant_ff <= rsp_grant_in;
   end

   // hold busy from accept until the result beat goes out
   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_granted_index = rsp_grant_ff;

endmodule

// ===== sv/bba_checker.sv =====
module bba_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic                     rsp_ok,
   input logic [bba_pkg::IDX_W-1:0] rsp_granted_index
);
   `include "buddy_block_allocator_top_defines.svh"

   `BBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `BBA_ASSERT_NOW(a_beat_idle, rsp_valid, !busy)
   `BBA_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_ok, rsp_granted_index == '0)
   `BBA_ASSERT_NOW(a_done_beat, $fell(busy), rsp_valid)

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_ok            (rsp_ok),
   .rsp_granted_index (rsp_granted_index)
);
